// File: design/psdff_pkg.sv
// ----------------------------------------------------------------------------
// Duplicate frame filter package
// Shared command and status types and register map constants.
// ----------------------------------------------------------------------------
`default_nettype none

package psdff_pkg;

  localparam int unsigned AddrW  = 32;
  localparam int unsigned IdW    = 8;
  localparam int unsigned TypeW  = 8;
  localparam int unsigned LimitW = 9;
  localparam int unsigned EntryW = AddrW + 2 * IdW;

  localparam int unsigned PaddrW = 3;
  localparam logic [PaddrW-3:0] RegCtrlLimit = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_FLUSH  = 4'b0100,
    ST_COMMIT = 4'b1000
  } state_e;

  typedef struct packed {
    logic start;
    logic scan_en;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// File: design/psdff_ctrl.sv
// ----------------------------------------------------------------------------
// Duplicate frame filter controller
// Sequences the slot table scan and the final commit of one frame header.
// ----------------------------------------------------------------------------
`default_nettype none

module psdff_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire psdff_pkg::sts_t sts_i,
  output psdff_pkg::cmd_t     cmd_o
);

  psdff_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= psdff_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    in_ready_o    = 1'b0;
    cmd_o.start   = 1'b0;
    cmd_o.scan_en = 1'b0;
    cmd_o.commit  = 1'b0;
    unique case (state_q)
      psdff_pkg::ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.start = in_valid_i;
        if (in_valid_i) begin
          state_d = psdff_pkg::ST_SCAN;
        end
      end
      psdff_pkg::ST_SCAN: begin
        cmd_o.scan_en = 1'b1;
        if (sts_i.scan_last) begin
          state_d = psdff_pkg::ST_FLUSH;
        end
      end
      psdff_pkg::ST_FLUSH: begin
        state_d = psdff_pkg::ST_COMMIT;
      end
      psdff_pkg::ST_COMMIT: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = psdff_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = psdff_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: design/psdff_dp.sv
// ----------------------------------------------------------------------------
// Duplicate frame filter datapath
// Slot table memory, scan compare, slot update and output word register.
// ----------------------------------------------------------------------------
`default_nettype none

module psdff_dp #(
  parameter int unsigned SenderSlots = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire psdff_pkg::cmd_t               cmd_i,
  output psdff_pkg::sts_t                    sts_o,
  input  wire logic [psdff_pkg::AddrW-1:0]   source_addr_i,
  input  wire logic [psdff_pkg::IdW-1:0]     frame_id_i,
  input  wire logic [psdff_pkg::TypeW-1:0]   frame_type_i,
  input  wire logic [psdff_pkg::LimitW-1:0]  limit_i,
  input  wire logic                          out_ready_i,
  output logic                               out_valid_o,
  output logic                               accept_o,
  output logic                               is_control_o,
  output logic                               slot_replaced_o
);

  localparam int unsigned IdxW = (SenderSlots > 1) ? $clog2(SenderSlots) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SenderSlots - 1);

  logic [psdff_pkg::EntryW-1:0] slot_mem_q [SenderSlots];
  logic [psdff_pkg::EntryW-1:0] rd_data_q;

  logic [psdff_pkg::AddrW-1:0] addr_q;
  logic [psdff_pkg::IdW-1:0]   id_q;
  logic                        ctrl_q;

  logic [IdxW-1:0] cnt_q;
  logic [IdxW-1:0] cmp_idx_q;
  logic            cmp_v_q;

  logic            hit_found_q;
  logic [IdxW-1:0] hit_idx_q;
  logic [psdff_pkg::IdW-1:0] hit_cid_q;
  logic [psdff_pkg::IdW-1:0] hit_did_q;
  logic            free_found_q;
  logic [IdxW-1:0] free_idx_q;

  logic [SenderSlots-1:0] valid_q;
  logic [SenderSlots-1:0] cseen_q;
  logic [SenderSlots-1:0] dseen_q;
  logic [IdxW-1:0]        ptr_q;

  logic                        rd_valid;
  logic [psdff_pkg::AddrW-1:0] rd_addr;
  logic [psdff_pkg::IdW-1:0]   rd_cid;
  logic [psdff_pkg::IdW-1:0]   rd_did;
  logic                        dup;
  logic                        replace;
  logic                        do_write;
  logic [IdxW-1:0]             tgt;
  logic [psdff_pkg::IdW-1:0]   new_cid;
  logic [psdff_pkg::IdW-1:0]   new_did;

  assign rd_addr  = rd_data_q[psdff_pkg::AddrW-1:0];
  assign rd_cid   = rd_data_q[psdff_pkg::AddrW +: psdff_pkg::IdW];
  assign rd_did   = rd_data_q[psdff_pkg::AddrW + psdff_pkg::IdW +: psdff_pkg::IdW];
  assign rd_valid = valid_q[cmp_idx_q];

  assign sts_o.scan_last = (cnt_q == LastIdx);
  assign sts_o.out_free  = !out_valid_o || out_ready_i;

  always_comb begin
    dup = 1'b0;
    if (hit_found_q) begin
      if (ctrl_q) begin
        dup = cseen_q[hit_idx_q] && (hit_cid_q == id_q);
      end else begin
        dup = dseen_q[hit_idx_q] && (hit_did_q == id_q);
      end
    end
    replace  = !hit_found_q && !free_found_q;
    do_write = cmd_i.commit && !dup;
    priority if (hit_found_q) begin
      tgt     = hit_idx_q;
      new_cid = ctrl_q ? id_q : hit_cid_q;
      new_did = ctrl_q ? hit_did_q : id_q;
    end else begin
      tgt     = free_found_q ? free_idx_q : ptr_q;
      new_cid = ctrl_q ? id_q : '0;
      new_did = ctrl_q ? '0 : id_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_en) begin
      rd_data_q <= slot_mem_q[cnt_q];
    end
    if (do_write) begin
      slot_mem_q[tgt] <= {new_did, new_cid, addr_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      addr_q <= source_addr_i;
      id_q   <= frame_id_i;
      ctrl_q <= ({1'b0, frame_type_i} < limit_i);
    end
    if (cmd_i.scan_en) begin
      cmp_idx_q <= cnt_q;
    end
    if (cmp_v_q && rd_valid && !hit_found_q && (rd_addr == addr_q)) begin
      hit_idx_q <= cmp_idx_q;
      hit_cid_q <= rd_cid;
      hit_did_q <= rd_did;
    end
    if (cmp_v_q && !rd_valid && !free_found_q) begin
      free_idx_q <= cmp_idx_q;
    end
    if (cmd_i.commit) begin
      accept_o        <= !dup;
      is_control_o    <= ctrl_q;
      slot_replaced_o <= !dup && replace;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      cmp_v_q      <= 1'b0;
      hit_found_q  <= 1'b0;
      free_found_q <= 1'b0;
      valid_q      <= '0;
      cseen_q      <= '0;
      dseen_q      <= '0;
      ptr_q        <= '0;
      out_valid_o  <= 1'b0;
    end else begin
      cmp_v_q <= cmd_i.scan_en;
      if (cmd_i.start) begin
        cnt_q        <= '0;
        hit_found_q  <= 1'b0;
        free_found_q <= 1'b0;
      end else begin
        if (cmd_i.scan_en && !sts_o.scan_last) begin
          cnt_q <= cnt_q + 1'b1;
        end
        if (cmp_v_q && rd_valid && (rd_addr == addr_q)) begin
          hit_found_q <= 1'b1;
        end
        if (cmp_v_q && !rd_valid) begin
          free_found_q <= 1'b1;
        end
      end
      if (do_write) begin
        valid_q[tgt] <= 1'b1;
        cseen_q[tgt] <= ctrl_q || (hit_found_q && cseen_q[tgt]);
        dseen_q[tgt] <= !ctrl_q || (hit_found_q && dseen_q[tgt]);
        if (replace) begin
          ptr_q <= (ptr_q == LastIdx) ? '0 : ptr_q + 1'b1;
        end
      end
      if (cmd_i.commit) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: design/per_source_duplicate_frame_filter.sv
// ----------------------------------------------------------------------------
// Per-sender duplicate frame filter
// Rejects a frame header whose id repeats the last id of its class from the
// same sender, keeping a table of sender slots with round-robin reuse.
//
// The input stream carries one header per word: tdata holds the sender
// address, frame id and frame type. The output stream returns one word per
// header with the accept, control class and slot reuse flags. The APB port
// holds the control type limit at byte address 0.
// After a header is taken, the controller scans the slot table one entry per
// cycle through the memory read port, passes a flush state and then commits
// the result; the next header is taken only after that commit, not during a
// scan. The result waits in an output register while the receiver stalls;
// the next header can be taken and scanned meanwhile, and only its commit
// waits for the register to drain. Reset clears all slot valid and seen bits,
// the replacement pointer and the limit; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module per_source_duplicate_frame_filter #(
  parameter int unsigned SenderSlots = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [31:0] source_addr, [39:32] frame_id, [47:40] frame_type
  input  wire logic [47:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [0] accept, [1] is_control, [2] slot_replaced, [7:3] zero
  output logic [7:0]       m_axis_tdata,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [psdff_pkg::PaddrW-1:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  psdff_pkg::cmd_t cmd;
  psdff_pkg::sts_t sts;

  logic [psdff_pkg::LimitW-1:0] limit_q;
  logic accept, is_control, slot_replaced;
  logic reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[psdff_pkg::PaddrW-1:2] == psdff_pkg::RegCtrlLimit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= '0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      limit_q <= pwdata[psdff_pkg::LimitW-1:0];
    end
  end

  assign prdata = reg_hit ? {{(32 - psdff_pkg::LimitW){1'b0}}, limit_q} : '0;

  psdff_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  psdff_dp #(
    .SenderSlots (SenderSlots)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .source_addr_i   (s_axis_tdata[31:0]),
    .frame_id_i      (s_axis_tdata[39:32]),
    .frame_type_i    (s_axis_tdata[47:40]),
    .limit_i         (limit_q),
    .out_ready_i     (m_axis_tready),
    .out_valid_o     (m_axis_tvalid),
    .accept_o        (accept),
    .is_control_o    (is_control),
    .slot_replaced_o (slot_replaced)
  );

  assign m_axis_tdata = {5'b0, slot_replaced, is_control, accept};

  a_commit_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result committed over an undelivered word");

  a_start_scans : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (cmd.scan_en && !s_axis_tready))
    else $error("accepted header did not start a table scan");

  a_dup_no_replace : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[0]) |-> !m_axis_tdata[2])
    else $error("duplicate frame reported a slot reuse");

endmodule

`default_nettype wire

// File: tb/tb_per_source_duplicate_frame_filter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Per-sender duplicate frame filter testbench
// Drives frame header words into the filter and checks every result word
// against a directed verdict or a cycle-free model of the sender table kept
// in the bench. A short table of directed words covers the field extremes,
// both classes, duplicates and slot reuse; random words, mostly from a small
// sender pool, then follow under several control type limits, with random
// gaps on both streams.
`default_nettype none

module tb_per_source_duplicate_frame_filter;

  localparam int unsigned Slots = 16;
  localparam int unsigned PhaseItems = 225;
  localparam int unsigned PoolSize = 20;
  localparam int unsigned HoldAt = 300;
  localparam int unsigned HoldCycles = 400;
  localparam logic [psdff_pkg::PaddrW-3:0] RegSpare = 1'b1;
  localparam logic [psdff_pkg::PaddrW-1:0] LimitAddr = {psdff_pkg::RegCtrlLimit, 2'b00};
  localparam logic [psdff_pkg::PaddrW-1:0] SpareAddr = {RegSpare, 2'b00};

  typedef struct packed {
    logic slot_replaced;
    logic is_control;
    logic accept;
  } verdict_t;

  typedef enum logic {ROW_FRAME, ROW_WRITE} row_kind_e;

  typedef struct {
    row_kind_e                    kind;
    logic [31:0]                  word;
    logic [psdff_pkg::PaddrW-1:0] reg_addr;
    logic [7:0]                   fid;
    logic [7:0]                   ftyp;
    bit                           typed;
    verdict_t                     want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // [31:0] source_addr, [39:32] frame_id, [47:40] frame_type
  logic [47:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // [0] accept, [1] is_control, [2] slot_replaced, [7:3] zero
  logic [7:0] m_axis_tdata;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [psdff_pkg::PaddrW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  logic [31:0] sender_tab [Slots];
  logic        slot_used  [Slots];
  logic [7:0]  ctrl_id    [Slots];
  logic        ctrl_seen  [Slots];
  logic [7:0]  data_id    [Slots];
  logic        data_seen  [Slots];
  logic [3:0]  rr_ptr = '0;
  logic [8:0]  limit_q = '0;

  verdict_t    verdict_q [$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned frames_sent = 0;
  int unsigned accepted_cnt = 0;
  int unsigned duplicate_cnt = 0;
  int unsigned replaced_cnt = 0;
  int unsigned control_cnt = 0;
  bit          send_quiet = 1'b0;
  bit          recv_quiet = 1'b0;

  // Bit order of want: {slot_replaced, is_control, accept}.
  row_t dir_rows [28] = '{
    '{ROW_FRAME, 32'h0000_0000, '0, 8'h00, 8'h00, 1'b1, 3'b001},
    '{ROW_FRAME, 32'h0000_0000, '0, 8'h00, 8'hFF, 1'b1, 3'b000},
    '{ROW_FRAME, 32'hFFFF_FFFF, '0, 8'hFF, 8'hFF, 1'b1, 3'b001},
    '{ROW_WRITE, 32'd256, LimitAddr, 8'h00, 8'h00, 1'b0, 3'b000},
    '{ROW_FRAME, 32'h0000_0000, '0, 8'h00, 8'hFF, 1'b1, 3'b011},
    '{ROW_FRAME, 32'h0000_0000, '0, 8'h00, 8'h00, 1'b1, 3'b010},
    '{ROW_WRITE, 32'd0, SpareAddr, 8'h00, 8'h00, 1'b0, 3'b000},
    '{ROW_FRAME, 32'hFFFF_FFFF, '0, 8'hFF, 8'h80, 1'b1, 3'b011},
    '{ROW_WRITE, 32'd128, LimitAddr, 8'h00, 8'h00, 1'b0, 3'b000},
    '{ROW_FRAME, 32'h0000_0000, '0, 8'h00, 8'h7F, 1'b1, 3'b010},
    '{ROW_FRAME, 32'h0000_0000, '0, 8'h00, 8'h80, 1'b1, 3'b000},
    '{ROW_FRAME, 32'h0000_0000, '0, 8'h01, 8'h80, 1'b1, 3'b001},
    '{ROW_FRAME, 32'h0A00_0001, '0, 8'h10, 8'h01, 1'b0, 3'b000},
    '{ROW_FRAME, 32'h0A00_0002, '0, 8'h20, 8'hF0, 1'b0, 3'b000},
    '{ROW_FRAME, 32'hC0A8_0103, '0, 8'h30, 8'h40, 1'b0, 3'b000},
    '{ROW_FRAME, 32'hC0A8_0104, '0, 8'h40, 8'hC0, 1'b0, 3'b000},
    '{ROW_FRAME, 32'h8000_0000, '0, 8'h80, 8'h7F, 1'b0, 3'b000},
    '{ROW_FRAME, 32'h7FFF_FFFF, '0, 8'h7F, 8'h81, 1'b0, 3'b000},
    '{ROW_FRAME, 32'h5555_5555, '0, 8'h55, 8'h55, 1'b0, 3'b000},
    '{ROW_FRAME, 32'hAAAA_AAAA, '0, 8'hAA, 8'hAA, 1'b0, 3'b000},
    '{ROW_FRAME, 32'h0000_0001, '0, 8'h01, 8'h00, 1'b0, 3'b000},
    '{ROW_FRAME, 32'hFFFF_FFFE, '0, 8'hFE, 8'hFE, 1'b0, 3'b000},
    '{ROW_FRAME, 32'h1234_5678, '0, 8'h12, 8'h34, 1'b0, 3'b000},
    '{ROW_FRAME, 32'h8765_4321, '0, 8'h87, 8'h65, 1'b0, 3'b000},
    '{ROW_FRAME, 32'h0F0F_0F0F, '0, 8'h0F, 8'hF0, 1'b0, 3'b000},
    '{ROW_FRAME, 32'hF0F0_F0F0, '0, 8'hF0, 8'h0F, 1'b0, 3'b000},
    '{ROW_FRAME, 32'h5A5A_5A5A, '0, 8'h42, 8'h10, 1'b1, 3'b111},
    '{ROW_FRAME, 32'h0000_0000, '0, 8'h00, 8'h80, 1'b1, 3'b101}
  };

  per_source_duplicate_frame_filter i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk_i = ~clk_i;

  initial begin : watchdog
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic verdict_t filter_frame(input logic [31:0] src, input logic [7:0] fid,
                                            input logic [7:0] ftyp);
    verdict_t v;
    int hit;
    int spare;
    hit = -1;
    spare = -1;
    v = '0;
    v.is_control = ({1'b0, ftyp} < limit_q);
    for (int s = 0; s < Slots; s++) begin
      if (slot_used[s]) begin
        if (hit < 0 && sender_tab[s] == src) hit = s;
      end else if (spare < 0) begin
        spare = s;
      end
    end
    if (hit >= 0) begin
      if (v.is_control ? (ctrl_seen[hit] && ctrl_id[hit] == fid)
                       : (data_seen[hit] && data_id[hit] == fid)) begin
        return v;
      end
    end else begin
      if (spare >= 0) begin
        hit = spare;
      end else begin
        hit = int'(rr_ptr);
        rr_ptr = rr_ptr + 4'd1;
        v.slot_replaced = 1'b1;
      end
      slot_used[hit]  = 1'b1;
      sender_tab[hit] = src;
      ctrl_seen[hit]  = 1'b0;
      data_seen[hit]  = 1'b0;
    end
    if (v.is_control) begin
      ctrl_id[hit]   = fid;
      ctrl_seen[hit] = 1'b1;
    end else begin
      data_id[hit]   = fid;
      data_seen[hit] = 1'b1;
    end
    v.accept = 1'b1;
    return v;
  endfunction

  task automatic offer_frame(input logic [31:0] src, input logic [7:0] fid,
                             input logic [7:0] ftyp, input bit typed, input verdict_t want);
    int unsigned gap;
    verdict_t predicted;
    gap = send_quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= {16'($urandom), $urandom};
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  <= {ftyp, fid, src};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = filter_frame(src, fid, ftyp);
    verdict_q.push_back(typed ? want : predicted);
    frames_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (verdict_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic reg_write(input logic [psdff_pkg::PaddrW-1:0] addr, input logic [31:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr[psdff_pkg::PaddrW-1:2] == psdff_pkg::RegCtrlLimit) limit_q = value[8:0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic limit_readback();
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    paddr   <= LimitAddr;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {23'd0, limit_q}) begin
      $display("%0t: limit readback expected %0d got %0d", $time, limit_q, prdata);
      mismatches++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic want, input logic got);
    if (got !== want) begin
      $display("%0t: word %0d %s expected %0b got %0b", $time, results_seen, name, want, got);
      mismatches++;
    end
  endtask

  initial begin : result_sink
    int unsigned stall;
    verdict_t want;
    verdict_t seen;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      stall = recv_quiet ? 0 : $urandom_range(0, 3);
      if (results_seen == HoldAt) stall = HoldCycles;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      seen = m_axis_tdata[2:0];
      if (verdict_q.size() == 0) begin
        $display("%0t: result word expected none got %b", $time, m_axis_tdata);
        mismatches++;
      end else begin
        want = verdict_q.pop_front();
        check_field("accept", want.accept, seen.accept);
        check_field("is_control", want.is_control, seen.is_control);
        check_field("slot_replaced", want.slot_replaced, seen.slot_replaced);
      end
      if (seen.accept === 1'b1) accepted_cnt++;
      else duplicate_cnt++;
      if (seen.slot_replaced === 1'b1) replaced_cnt++;
      if (seen.is_control === 1'b1) control_cnt++;
      results_seen++;
      if (results_seen % 64 == 0) recv_quiet = ($urandom_range(0, 2) == 0);
    end
  end

  initial begin : frame_source
    int phase_limits [7];
    logic [31:0] pool [PoolSize];
    logic [31:0] src;
    logic [7:0]  fid;
    logic [7:0]  ftyp;
    int unsigned pick;
    bit          have_last;
    int          edge_type;

    phase_limits = '{256, 0, 1, 255, -1, 128, -1};
    for (int s = 0; s < Slots; s++) begin
      slot_used[s] = 1'b0;
      ctrl_seen[s] = 1'b0;
      data_seen[s] = 1'b0;
    end
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    limit_readback();

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_WRITE) begin
        drain_results();
        reg_write(dir_rows[r].reg_addr, dir_rows[r].word);
        limit_readback();
      end else begin
        offer_frame(dir_rows[r].word, dir_rows[r].fid, dir_rows[r].ftyp,
                    dir_rows[r].typed, dir_rows[r].want);
      end
    end

    foreach (phase_limits[p]) begin
      drain_results();
      reg_write(LimitAddr, (phase_limits[p] < 0) ? $urandom_range(2, 254)
                                                  : 32'(phase_limits[p]));
      limit_readback();
      foreach (pool[k]) pool[k] = $urandom;
      have_last = 1'b0;
      for (int n = 0; n < PhaseItems; n++) begin
        if (p == 1 && n == 100) drain_results();
        if (n % 64 == 0) send_quiet = ($urandom_range(0, 2) == 0);
        pick = $urandom_range(0, 99);
        if (!(pick < 15 && have_last)) begin
          src  = (pick < 25) ? $urandom : pool[$urandom_range(0, PoolSize - 1)];
          fid  = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 3))
                                             : 8'($urandom_range(0, 255));
          ftyp = 8'($urandom_range(0, 255));
          if (pick >= 25 && pick < 35) begin
            edge_type = int'(limit_q) - int'($urandom_range(0, 1));
            ftyp = 8'((edge_type < 0) ? 0 : (edge_type > 255) ? 255 : edge_type);
          end
        end
        offer_frame(src, fid, ftyp, 1'b0, 3'b000);
        have_last = 1'b1;
      end
    end

    drain_results();
    repeat (2 * Slots + 8) @(negedge clk_i);
    $display("Sent %0d frame words under %0d limit settings; %0d results checked.",
             frames_sent, 7 + 3, results_seen);
    $display("Results: %0d accepted, %0d duplicates, %0d slot reuses, %0d control.",
             accepted_cnt, duplicate_cnt, replaced_cnt, control_cnt);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: per_source_duplicate_frame_filter.f
design/psdff_pkg.sv
design/psdff_ctrl.sv
design/psdff_dp.sv
design/per_source_duplicate_frame_filter.sv
tb/tb_per_source_duplicate_frame_filter.sv
